FILE: sv/lfbe_pkg.sv
// Package for the LED frame buffer engine: command codes, controller states,
// result record and default sizes. No dependencies.
package lfbe_pkg;

	localparam int LFBE_ROWS     = 16;
	localparam int LFBE_ROW_BITS = 32;

	localparam int ACTION_W   = 4;
	localparam int ROW_W      = 4;
	localparam int COLUMN_W   = 5;
	localparam int ROW_WORD_W = 32;
	localparam int BYTE_W     = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR    = 4'd0,
		ACT_SETPIX   = 4'd1,
		ACT_CLRPIX   = 4'd2,
		ACT_FILLROW  = 4'd3,
		ACT_BLANKROW = 4'd4,
		ACT_SETCOL   = 4'd5,
		ACT_CLRCOL   = 4'd6,
		ACT_INVERT   = 4'd7,
		ACT_ROWSDOWN = 4'd8,
		ACT_ROTBITS  = 4'd9,
		ACT_READPIX  = 4'd10,
		ACT_LOADROW  = 4'd11,
		ACT_REFRESH  = 4'd12
	} lfbe_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIXWR,
		ST_READ,
		ST_SWEEP,
		ST_REF
	} lfbe_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              pixel_value;
		logic              last;
	} lfbe_res_t;

endpackage

FILE: sv/led_frame_buffer_engine_core.sv
// Top level of the LED frame buffer engine: stream ports, index reduction,
// engine and output register. Depends on lfbe_pkg, lfbe_engine, lfbe_obuf.
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    tdata: action, row, column, row_word
//  m_axis   out  m_axis_tvalid/tready    tdata: out_byte, pixel_value; tlast
//
// Fill row, blank row, load row: a single RAM write. Set/clear pixel: RAM read,
// then write back. Read pixel: RAM read, then result push, which waits out any output stall.
// Whole-frame commands: one row per cycle through the RAM port.
// Refresh: ROWS*ceil(ROW_BITS/8) bytes, one byte per cycle, stalls with
// m_axis_tready. Reset clears per-row valid bits so the frame reads dark.
module led_frame_buffer_engine_core #(
	parameter int ROWS     = lfbe_pkg::LFBE_ROWS,
	parameter int ROW_BITS = lfbe_pkg::LFBE_ROW_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // action[3:0] row[7:4] column[12:8] row_word[44:13]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_byte[7:0] pixel_value[8]
	output logic        m_axis_tlast
);
	import lfbe_pkg::*;

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(ROW_BITS);

	function automatic logic [RW-1:0] reduce_row(input logic [ROW_W-1:0] v);
		logic [6:0] t;
		t = 7'(v);
		for (int i = 0; i < 8; i++) begin
			if (t >= 7'(ROWS)) t = t - 7'(ROWS);
		end
		return RW'(t);
	endfunction

	function automatic logic [CW-1:0] reduce_col(input logic [COLUMN_W-1:0] v);
		logic [6:0] t;
		t = 7'(v);
		for (int i = 0; i < 4; i++) begin
			if (t >= 7'(ROW_BITS)) t = t - 7'(ROW_BITS);
		end
		return CW'(t);
	endfunction

	lfbe_action_t        action;
	logic [RW-1:0]       row_idx;
	logic [CW-1:0]       col_idx;
	logic [ROW_BITS-1:0] word;
	logic                res_push, res_space;
	lfbe_res_t           res, res_out;

	assign action  = lfbe_action_t'(s_axis_tdata[3:0]);
	assign row_idx = reduce_row(s_axis_tdata[7:4]);
	assign col_idx = reduce_col(s_axis_tdata[12:8]);
	assign word    = ROW_BITS'(s_axis_tdata[44:13]);

	lfbe_engine #(.ROWS(ROWS), .ROW_BITS(ROW_BITS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.action    (action),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.word      (word),
		.res_push  (res_push),
		.res       (res),
		.res_space (res_space)
	);

	lfbe_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.res_in    (res),
		.space     (res_space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_out   (res_out)
	);

	assign m_axis_tdata = {7'b0, res_out.pixel_value, res_out.out_byte};
	assign m_axis_tlast = res_out.last;

`ifndef SYNTHESIS
	// refresh holds off new commands while streaming
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[3:0] == ACT_REFRESH
		|=> !s_axis_tready)
		else $error("command accepted during refresh start");

	// a pixel bit only comes with a single-result transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("pixel result without last");

	// edit commands produce no result
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
		(s_axis_tdata[3:0] == ACT_SETPIX || s_axis_tdata[3:0] == ACT_LOADROW)
		|=> !m_axis_tvalid)
		else $error("edit command produced a result");
`endif

endmodule

FILE: sv/lfbe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read-first on a same-address collision. No dependencies.
module lfbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/lfbe_obuf.sv
// Output register stage for result transactions.
// Depends on lfbe_pkg (result record).
module lfbe_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lfbe_pkg::lfbe_res_t res_in,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output lfbe_pkg::lfbe_res_t res_out
);
	import lfbe_pkg::*;

	logic      valid_q;
	lfbe_res_t res_q;

	assign space = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (space && push) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

FILE: sv/lfbe_engine.sv
// Command sequencer and read-modify-write datapath around the frame RAM.
// Depends on lfbe_pkg, lfbe_ram.
module lfbe_engine #(
	parameter int ROWS     = lfbe_pkg::LFBE_ROWS,
	parameter int ROW_BITS = lfbe_pkg::LFBE_ROW_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  lfbe_pkg::lfbe_action_t      action,
	input  logic [$clog2(ROWS)-1:0]     row_idx,
	input  logic [$clog2(ROW_BITS)-1:0] col_idx,
	input  logic [ROW_BITS-1:0]         word,
	output logic                        res_push,
	output lfbe_pkg::lfbe_res_t         res,
	input  logic                        res_space
);
	import lfbe_pkg::*;

	localparam int RW   = $clog2(ROWS);
	localparam int CW   = $clog2(ROW_BITS);
	localparam int CNTW = $clog2(ROWS + 1);
	localparam int BPR  = (ROW_BITS + 7) / 8;
	localparam int BW   = (BPR > 1) ? $clog2(BPR) : 1;
	localparam int PADW = BPR * 8;

	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(ROWS);
	localparam logic [RW-1:0]   ROW_LAST = RW'(ROWS - 1);
	localparam logic [BW-1:0]   BYTE_LAST = BW'(BPR - 1);

	lfbe_state_t          state_q, state_d;
	lfbe_action_t         act_q;
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic [CNTW-1:0]      cnt_q;
	logic [RW-1:0]        rrow_q;
	logic [BW-1:0]        byte_q;
	logic [ROWS-1:0]      valid_q;
	logic                 rd_valid_s1;

	logic                 rd_en, wr_en;
	logic [RW-1:0]        rd_addr, wr_addr;
	logic [ROW_BITS-1:0]  wr_data, rd_data, row_data, sweep_data, pix_mask;
	logic [PADW-1:0]      row_pad;
	logic                 accept, ref_last, byte_last;

	lfbe_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// rows never written since reset read dark
	assign row_data  = rd_valid_s1 ? rd_data : '0;
	assign row_pad   = PADW'(row_data);
	assign pix_mask  = ROW_BITS'(1) << col_q;
	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign byte_last = (byte_q == BYTE_LAST);
	assign ref_last  = byte_last && (rrow_q == ROW_LAST);

	always_comb begin
		unique case (act_q)
			ACT_CLEAR:   sweep_data = '0;
			ACT_SETCOL:  sweep_data = row_data | pix_mask;
			ACT_CLRCOL:  sweep_data = row_data & ~pix_mask;
			ACT_INVERT:  sweep_data = ~row_data;
			ACT_ROTBITS: sweep_data = {row_data[ROW_BITS-2:0], row_data[ROW_BITS-1]};
			default:     sweep_data = row_data;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (action)
						ACT_SETPIX, ACT_CLRPIX: state_d = ST_PIXWR;
						ACT_READPIX:            state_d = ST_READ;
						ACT_REFRESH:            state_d = ST_REF;
						ACT_CLEAR, ACT_SETCOL, ACT_CLRCOL, ACT_INVERT,
						ACT_ROWSDOWN, ACT_ROTBITS: state_d = ST_SWEEP;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_PIXWR: state_d = ST_IDLE;
			ST_READ: begin
				if (res_space) state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (cnt_q == CNT_LAST) state_d = ST_IDLE;
			end
			ST_REF: begin
				if (res_space && ref_last) state_d = ST_IDLE;
			end
		endcase
	end

	// RAM and result controls
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = row_q;
		wr_data  = row_data;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (action)
						ACT_SETPIX, ACT_CLRPIX, ACT_READPIX: begin
							rd_en   = 1'b1;
							rd_addr = row_idx;
						end
						ACT_CLEAR, ACT_SETCOL, ACT_CLRCOL, ACT_INVERT,
						ACT_ROWSDOWN, ACT_ROTBITS, ACT_REFRESH: begin
							rd_en = 1'b1;
						end
						ACT_FILLROW: begin
							wr_en   = 1'b1;
							wr_addr = row_idx;
							wr_data = '1;
						end
						ACT_BLANKROW: begin
							wr_en   = 1'b1;
							wr_addr = row_idx;
							wr_data = '0;
						end
						ACT_LOADROW: begin
							wr_en   = 1'b1;
							wr_addr = row_idx;
							wr_data = word;
						end
						default: ;
					endcase
				end
			end
			ST_PIXWR: begin
				wr_en   = 1'b1;
				wr_data = (act_q == ACT_SETPIX) ? (row_data | pix_mask)
				                                : (row_data & ~pix_mask);
			end
			ST_READ: begin
				res_push        = res_space;
				res.pixel_value = row_data[col_q];
				res.last        = 1'b1;
			end
			ST_SWEEP: begin
				rd_en   = (cnt_q != CNT_LAST);
				rd_addr = cnt_q[RW-1:0];
				wr_en   = 1'b1;
				wr_data = sweep_data;
				if (act_q == ACT_ROWSDOWN) begin
					wr_addr = (cnt_q == CNT_LAST) ? '0 : cnt_q[RW-1:0];
				end else begin
					wr_addr = RW'(cnt_q - 1'b1);
				end
			end
			ST_REF: begin
				res_push     = res_space;
				res.out_byte = row_pad[byte_q*8 +: 8];
				res.last     = ref_last;
				rd_en        = res_space && byte_last && !ref_last;
				rd_addr      = rrow_q + 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rrow_q      <= '0;
			byte_q      <= '0;
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
			if (accept) begin
				cnt_q  <= CNTW'(1);
				rrow_q <= '0;
				byte_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_REF && res_space) begin
				if (byte_last) begin
					byte_q <= '0;
					rrow_q <= ref_last ? '0 : rrow_q + 1'b1;
				end else begin
					byte_q <= byte_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			row_q <= row_idx;
			col_q <= col_idx;
		end
	end

endmodule
